// ===== design/mma_pkg.sv =====
// Shared constants, request codes and sequencer states for the moving average block.
package mma_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned AVG_W      = 40;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned WIN_REG_W  = 7;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CHAN_W     = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned CHANNELS_DEF   = 4;
  localparam int unsigned WINDOW_MAX_DEF = 64;

  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_BASE  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END       = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_TICK,
    ST_DIVIDE,
    ST_DONE
  } state_e;

endpackage

// ===== design/mma_ring.sv =====
// Sample ring memory shared by all channels, one write and one registered read port.
module mma_ring #(
  parameter int unsigned DEPTH = mma_pkg::CHANNELS_DEF * mma_pkg::WINDOW_MAX_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [mma_pkg::SAMPLE_W-1:0]   wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [mma_pkg::SAMPLE_W-1:0]   rdata_o
);

  logic [mma_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [mma_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mma_div.sv =====
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module mma_div #(
  parameter int unsigned DW = 46,
  parameter int unsigned EW = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic [EW-1:0]        divisor_i,
  output logic                 done_o,
  output logic [DW-1:0]        quotient_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]    acc_q, acc_d;
  logic [EW-1:0]    rem_q, rem_d;
  logic [EW-1:0]    div_q, div_d;
  logic             neg_q, neg_d;
  logic [EW:0]      shifted;
  logic [EW:0]      diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, acc_q[DW-1]};
    diff    = shifted - {1'b0, div_q};
    ge      = (shifted >= {1'b0, div_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DW);
      acc_d  = dividend_i[DW-1] ? (DW'(0) - dividend_i) : dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      neg_d  = dividend_i[DW-1];
    end else if (busy_q) begin
      acc_d = {acc_q[DW-2:0], ge};
      rem_d = ge ? diff[EW-1:0] : shifted[EW-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DW'(0) - acc_q) : acc_q;

endmodule

// ===== design/multirate_moving_average.sv =====
// Multi-channel multirate boxcar averager: sequencer, channel state and result register.
//
// Input channel (in_valid_i / in_stall_o) carries one request per beat: a sample
// offer, a tick, or a read of a channel's window average. Each beat yields exactly
// one result beat on the output channel (out_valid_o / out_stall_i); offers report
// sample_taken_o, reads report average_value_o (signed, 8 fraction bits).
// The block handles one request at a time and holds in_stall_o while it works:
//   sample offer: ring read, then sum update and ring write
//   tick:         decode then one channel's phase per cycle
//   read:         decode, then the serial divider (one quotient bit per cycle)
//   other:        straight to the result
// after each, the result moves into the output register. A new request is
// taken while the previous result still waits in the output register; a stalled
// receiver only delays the final handover into that register.
// Configuration writes (cfg_valid_i / cfg_ready_o) are always taken. A window
// write clears that channel's window; a rate write restarts its phase.
// Reset clears all channel state at once; ring entries are tracked by a per-channel
// wrap flag, so no clearing pass is needed.
module multirate_moving_average #(
  parameter int unsigned CHANNELS   = mma_pkg::CHANNELS_DEF,
  parameter int unsigned WINDOW_MAX = mma_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mma_pkg::REQ_W-1:0]           req_type_i,
  input  logic [mma_pkg::CHAN_W-1:0]          channel_i,
  input  logic signed [mma_pkg::SAMPLE_W-1:0] sample_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mma_pkg::AVG_W-1:0]    average_value_o,
  output logic                                sample_taken_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mma_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mma_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned EW    = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_W = mma_pkg::SAMPLE_W + $clog2(WINDOW_MAX);
  localparam int unsigned DW    = SUM_W + mma_pkg::FRAC_W;
  localparam int unsigned DEPTH = CHANNELS * WINDOW_MAX;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [EW-1:0] eff_win(input logic [mma_pkg::WIN_REG_W-1:0] w);
    if (w == '0) begin
      return EW'(1);
    end else if (32'(w) > WINDOW_MAX) begin
      return EW'(WINDOW_MAX);
    end else begin
      return EW'(w);
    end
  endfunction

  mma_pkg::state_e state_q, state_d;

  logic [mma_pkg::RATE_W-1:0]    rate_q   [CHANNELS];
  logic [mma_pkg::WIN_REG_W-1:0] window_q [CHANNELS];
  logic [mma_pkg::RATE_W-1:0]    phase_q  [CHANNELS];
  logic [IW-1:0]                 widx_q   [CHANNELS];
  logic                          wrap_q   [CHANNELS];
  logic signed [SUM_W-1:0]       sum_q    [CHANNELS];

  logic [CW-1:0]                 ch_q;
  logic [CW-1:0]                 tick_q;
  logic [mma_pkg::SAMPLE_W-1:0]  sample_q;
  logic signed [mma_pkg::AVG_W-1:0] pend_avg_q;
  logic                          pend_taken_q;
  logic                          out_valid_q;
  logic signed [mma_pkg::AVG_W-1:0] out_avg_q;
  logic                          out_taken_q;

  logic                          in_accept;
  logic [CW-1:0]                 in_ch;
  logic                          ch_ok;
  logic                          store_ok;
  logic                          out_load;
  logic                          tick_last;
  logic                          div_start;
  logic                          div_done;
  logic [DW-1:0]                 div_quot;
  logic signed [DW-1:0]          div_dividend;
  logic                          mem_we;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic [AW-1:0]                 mem_waddr;
  logic [mma_pkg::SAMPLE_W-1:0]  mem_rdata;
  logic signed [SUM_W-1:0]       old_val;
  logic signed [SUM_W-1:0]       new_sum;
  logic [EW-1:0]                 cur_win;
  logic                          idx_wrap;
  logic [mma_pkg::RATE_W:0]      phase_inc;
  logic [mma_pkg::CFG_IDX_W-1:0] cfg_off;
  logic                          cfg_rate_we;
  logic                          cfg_win_we;
  logic [CW-1:0]                 cfg_ch;

  // Request decode
  always_comb begin
    in_accept    = in_valid_i && !in_stall_o;
    in_ch        = channel_i[CW-1:0];
    ch_ok        = (32'(channel_i) < CHANNELS);
    store_ok     = ch_ok && (rate_q[in_ch] != '0) && (phase_q[in_ch] == '0);
    tick_last    = (tick_q == CW'(CHANNELS - 1));
    div_dividend = {sum_q[in_ch], {mma_pkg::FRAC_W{1'b0}}};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mma_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (req_type_i == mma_pkg::REQ_SAMPLE && store_ok) begin
            state_d = mma_pkg::ST_SAMPLE;
          end else if (req_type_i == mma_pkg::REQ_TICK) begin
            state_d = mma_pkg::ST_TICK;
          end else if (req_type_i == mma_pkg::REQ_READ && ch_ok) begin
            state_d = mma_pkg::ST_DIVIDE;
          end else begin
            state_d = mma_pkg::ST_DONE;
          end
        end
      end
      mma_pkg::ST_SAMPLE: state_d = mma_pkg::ST_DONE;
      mma_pkg::ST_TICK: begin
        if (tick_last) begin
          state_d = mma_pkg::ST_DONE;
        end
      end
      mma_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_d = mma_pkg::ST_DONE;
        end
      end
      mma_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = mma_pkg::ST_IDLE;
        end
      end
      default: state_d = mma_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    div_start  = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    case (state_q)
      mma_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        div_start  = in_accept && (req_type_i == mma_pkg::REQ_READ) && ch_ok;
        mem_re     = in_accept && (req_type_i == mma_pkg::REQ_SAMPLE) && store_ok;
      end
      mma_pkg::ST_SAMPLE: mem_we = 1'b1;
      mma_pkg::ST_DONE:   out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // Sample path: drop the oldest entry, add the new one
  always_comb begin
    mem_raddr = AW'(32'(in_ch) * WINDOW_MAX + 32'(widx_q[in_ch]));
    mem_waddr = AW'(32'(ch_q) * WINDOW_MAX + 32'(widx_q[ch_q]));
    cur_win   = eff_win(window_q[ch_q]);
    idx_wrap  = ((32'(widx_q[ch_q]) + 32'd1) >= 32'(cur_win));
    old_val   = wrap_q[ch_q] ? SUM_W'(signed'(mem_rdata)) : '0;
    new_sum   = sum_q[ch_q] - old_val + SUM_W'(signed'(sample_q));
    phase_inc = {1'b0, phase_q[tick_q]} + (mma_pkg::RATE_W + 1)'(1);
  end

  // Configuration decode
  always_comb begin
    cfg_ready_o = 1'b1;
    cfg_rate_we = 1'b0;
    cfg_win_we  = 1'b0;
    cfg_off     = '0;
    if (cfg_index_i < mma_pkg::CFG_WIN_BASE) begin
      cfg_off     = cfg_index_i - mma_pkg::CFG_RATE_BASE;
      cfg_rate_we = cfg_valid_i && (32'(cfg_off) < CHANNELS);
    end else if (cfg_index_i < mma_pkg::CFG_END) begin
      cfg_off    = cfg_index_i - mma_pkg::CFG_WIN_BASE;
      cfg_win_we = cfg_valid_i && (32'(cfg_off) < CHANNELS);
    end
    cfg_ch = cfg_off[CW-1:0];
  end

  mma_ring #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(sample_q),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  mma_div #(
    .DW(DW),
    .EW(EW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (eff_win(window_q[in_ch])),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  // Channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mma_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      tick_q      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        rate_q[c]   <= '0;
        window_q[c] <= mma_pkg::WIN_REG_W'(1);
        phase_q[c]  <= '0;
        widx_q[c]   <= '0;
        wrap_q[c]   <= 1'b0;
        sum_q[c]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (in_accept) begin
        tick_q <= '0;
      end else if (state_q == mma_pkg::ST_TICK) begin
        tick_q <= tick_q + CW'(1);
        if (rate_q[tick_q] != '0) begin
          phase_q[tick_q] <= (phase_inc >= {1'b0, rate_q[tick_q]}) ?
                             '0 : phase_inc[mma_pkg::RATE_W-1:0];
        end
      end
      if (state_q == mma_pkg::ST_SAMPLE) begin
        sum_q[ch_q]  <= new_sum;
        widx_q[ch_q] <= idx_wrap ? '0 : IW'(32'(widx_q[ch_q]) + 32'd1);
        if (idx_wrap) begin
          wrap_q[ch_q] <= 1'b1;
        end
      end
      if (cfg_rate_we) begin
        rate_q[cfg_ch]  <= cfg_data_i[mma_pkg::RATE_W-1:0];
        phase_q[cfg_ch] <= '0;
      end
      if (cfg_win_we) begin
        window_q[cfg_ch] <= cfg_data_i[mma_pkg::WIN_REG_W-1:0];
        widx_q[cfg_ch]   <= '0;
        wrap_q[cfg_ch]   <= 1'b0;
        sum_q[cfg_ch]    <= '0;
      end
    end
  end

  // Request payload and result registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q         <= in_ch;
      sample_q     <= sample_value_i;
      pend_avg_q   <= '0;
      pend_taken_q <= 1'b0;
    end
    if (state_q == mma_pkg::ST_SAMPLE) begin
      pend_taken_q <= 1'b1;
    end
    if (state_q == mma_pkg::ST_DIVIDE && div_done) begin
      pend_avg_q <= div_quot[mma_pkg::AVG_W-1:0];
    end
    if (out_load) begin
      out_avg_q   <= pend_avg_q;
      out_taken_q <= pend_taken_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign average_value_o = out_avg_q;
  assign sample_taken_o  = out_taken_q;

  a_taken_no_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_taken_o |-> average_value_o == '0)
    else $error("stored sample reported with nonzero average");

  a_widx_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(widx_q[0]) < 32'(eff_win(window_q[0])))
    else $error("ring write index beyond window");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == mma_pkg::ST_DIVIDE)
    else $error("divider finished outside of read");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mma_pkg::ST_DONE && !out_valid_o |=> out_valid_o)
    else $error("result not moved into free output register");

endmodule
